[hdl/b64e_pkg.sv]
// Shared types, constants and the sextet-to-character map for the Base64 encoder.
`default_nettype none
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic CSR_URL_ALPHABET = 1'b0;
   localparam logic CSR_PAD_ENABLE   = 1'b1;

   // Position within the three-byte group.
   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_SECOND = 3'b010,
      PH_THIRD  = 3'b100
   } phase_type;

   // One classified byte: up to two sextets followed by up to two pad characters.
   typedef struct packed {
      logic [5:0] sx0;
      logic [5:0] sx1;
      logic       two_sext;
      logic [1:0] n_pad;
      logic       last;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = url ? 8'h2D : 8'h2B;
      end else begin
         r = url ? 8'h5F : 8'h2F;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/b64e_front.sv]
// Front end: takes bytes, tracks the group position and builds one job per byte.
`default_nettype none
module b64e_front
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   input  wire logic       pad_enable,
   input  wire logic       queue_full,
   output logic            job_push,
   output job_type         job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       xfer;

   assign req_ready = !queue_full;
   assign xfer      = req_valid && req_ready;
   assign job_push  = xfer;

   always_comb begin
      job          = '0;
      job.last     = req_in_last;
      phase_in     = phase_ff;
      carry_in     = carry_ff;
      unique case (phase_ff)
         PH_SECOND: begin
            job.sx0 = {carry_ff[1:0], req_in_byte[7:4]};
            if (req_in_last) begin
               job.sx1      = {req_in_byte[3:0], 2'b00};
               job.two_sext = 1'b1;
               job.n_pad    = pad_enable ? 2'd1 : 2'd0;
            end else begin
               carry_in = req_in_byte[3:0];
               phase_in = PH_THIRD;
            end
         end
         PH_THIRD: begin
            job.sx0      = {carry_ff, req_in_byte[7:6]};
            job.sx1      = req_in_byte[5:0];
            job.two_sext = 1'b1;
            carry_in     = 4'd0;
            phase_in     = PH_FIRST;
         end
         default: begin
            job.sx0 = req_in_byte[7:2];
            if (req_in_last) begin
               job.sx1      = {req_in_byte[1:0], 4'b0000};
               job.two_sext = 1'b1;
               job.n_pad    = pad_enable ? 2'd2 : 2'd0;
            end else begin
               carry_in = {2'b00, req_in_byte[1:0]};
               phase_in = PH_SECOND;
            end
         end
      endcase
      if (req_in_last) begin
         carry_in = 4'd0;
         phase_in = PH_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= 4'd0;
      end else if (xfer) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule
`default_nettype wire

[hdl/b64e_queue.sv]
// Small job FIFO between the front end and the character emitter.
`default_nettype none
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         valid,
   output job_type      head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type           entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign valid   = (count_ff != '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers wrap naturally; depth must be a power of two, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule
`default_nettype wire

[hdl/b64e_back.sv]
// Back end: walks the current job one character per cycle into the output register while rsp_ready does not stall it.
`default_nettype none
module b64e_back
   import b64e_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    url_alphabet,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_out_last
);

   job_type    cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;

   logic [2:0] total;
   logic       last_char;
   logic       out_free;
   logic       emit;
   logic       done;
   logic [7:0] char_in;

   assign total     = 3'd1 + {2'b00, cur_ff.two_sext} + {1'b0, cur_ff.n_pad};
   assign last_char = ({1'b0, idx_ff} == (total - 3'd1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && out_free;
   assign done      = emit && last_char;
   assign job_pop   = job_valid && (!cur_valid_ff || done);

   // sextets come first, pad characters fill the rest of the job
   always_comb begin
      if (idx_ff == 2'd0) begin
         char_in = sextet_char(cur_ff.sx0, url_alphabet);
      end else if (idx_ff == 2'd1 && cur_ff.two_sext) begin
         char_in = sextet_char(cur_ff.sx1, url_alphabet);
      end else begin
         char_in = PAD_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
      if (emit) begin
         char_ff <= char_in;
         last_ff <= cur_ff.last && last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (job_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < total))
      else $error("character index ran past the end of the job");

   a_idle_idx_zero: assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> (idx_ff == 2'd0))
      else $error("character index not cleared while no job is held");

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && char_ff == $past(char_in)))
      else $error("emitted character not captured in the output register");

endmodule
`default_nettype wire

[hdl/base64_encoder_core.sv]
// Base64 encoder top level: control registers and the front, queue and back stages.
// A byte's first character passes through the queue entry, the back end's job register and
// the output register. Throughput: one character per cycle while rsp_ready does not stall,
// set by the single output register of the back end; a byte yields one character at group
// positions one and two, two at position three, and up to four for a last byte with padding.
// Reset (synchronous): group position and queue cleared, url_alphabet 0, pad_enable 1.
`default_nettype none
module base64_encoder_core
   import b64e_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_out_last,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic       csr_wdata
);

   logic    url_alphabet_ff;
   logic    pad_enable_ff;
   logic    queue_full;
   logic    job_push;
   job_type push_job;
   logic    job_pop;
   logic    job_valid;
   job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
         pad_enable_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_URL_ALPHABET: url_alphabet_ff <= csr_wdata;
            CSR_PAD_ENABLE:   pad_enable_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .pad_enable  (pad_enable_ff),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job         (push_job)
   );

   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .head     (head_job)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_alphabet_ff),
      .job_valid    (job_valid),
      .job          (head_job),
      .job_pop      (job_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule
`default_nettype wire
